// File: rtl/core/crp_pkg.sv
// Shared types, constants and helpers for the color ramp generator.
`timescale 1ns / 1ps
package crp_pkg;

  localparam int COLOR_W  = 24;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 7;
  localparam int FRAC_W   = 16;
  localparam int SEG_W    = 6;
  localparam int PROD_W   = 14;
  localparam int DVS_W    = 7;
  localparam int DVD_W    = FRAC_W + DVS_W;
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = FRAC_W / DIV_BITS_PER_CYC;
  localparam int QDEPTH   = 2;
  localparam logic [CFG_W-1:0] OUT_COUNT_RST = 7'd64;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GEN  = 1'b1
  } crp_op_t;

  typedef struct packed {
    crp_op_t              op;
    logic [COLOR_W-1:0]   color;
  } crp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SEGST,
    ST_SEGW,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_MUL,
    ST_DIV,
    ST_DIVW,
    ST_EMIT,
    ST_LASTA,
    ST_LASTB,
    ST_LAST
  } crp_state_t;

  // which of the three per-channel divisions is running
  typedef enum logic [1:0] {
    PH_HI,
    PH_LO,
    PH_FRAC
  } crp_phase_t;

  // channel 0 = red, 1 = green, 2 = blue
  function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] c, input int k);
    chan = c[COLOR_W-1-CH_W*k -: CH_W];
  endfunction

endpackage

// File: rtl/core/crp_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module crp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/crp_div.sv
// Iterative restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
module crp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [crp_pkg::DVD_W-1:0]   dividend,
  input  logic [crp_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [crp_pkg::FRAC_W-1:0]  quotient
);
  import crp_pkg::*;

  localparam int SW = $clog2(DIV_CYCLES);

  logic              running;
  logic [SW-1:0]     step;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  rem_next;
  logic [DVS_W-1:0]  dvs;
  logic [FRAC_W-1:0] quotient_next;
  logic [DVS_W:0]    trial;

  // dividend high part must be below the divisor so the quotient fits FRAC_W bits
  always_comb begin
    rem_next      = rem;
    quotient_next = quotient;
    trial         = '0;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      trial         = {rem_next, quotient_next[FRAC_W-1]};
      quotient_next = {quotient_next[FRAC_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial            = trial - {1'b0, dvs};
        quotient_next[0] = 1'b1;
      end
      rem_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        rem      <= dividend[DVD_W-1:FRAC_W];
        quotient <= dividend[FRAC_W-1:0];
        dvs      <= divisor;
      end else if (running) begin
        rem      <= rem_next;
        quotient <= quotient_next;
        step     <= step + 1'b1;
        if (step == SW'(DIV_CYCLES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider restarted while running");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");

endmodule

// File: rtl/core/crp_front.sv
// Front end: takes items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module crp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [crp_pkg::COLOR_W-1:0]   stop_color,
  input  logic                          pop,
  output crp_pkg::crp_cmd_t             cmd,
  output logic                          cmd_valid
);
  import crp_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int FW = $clog2(QDEPTH + 1);

  crp_cmd_t      slots [QDEPTH];
  crp_cmd_t      incoming;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          do_pop;

  assign busy      = (fill == FW'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill != '0);
  assign do_pop    = pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_comb begin
    incoming.op    = kind ? OP_GEN : OP_LOAD;
    incoming.color = kind ? '0 : stop_color;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/crp_back.sv
// Back end: stop table, segment sequencer and per-channel interpolation lanes.
`timescale 1ns / 1ps
module crp_back #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_OUT   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  crp_pkg::crp_cmd_t            cmd,
  input  logic                         cmd_valid,
  output logic                         pop,
  input  logic [crp_pkg::CFG_W-1:0]    out_count,
  output logic                         result_valid,
  output logic [crp_pkg::IDX_W-1:0]    entry_index,
  output logic [crp_pkg::CH_W-1:0]     red_byte,
  output logic [crp_pkg::CH_W-1:0]     green_byte,
  output logic [crp_pkg::CH_W-1:0]     blue_byte,
  output logic [crp_pkg::FRAC_W-1:0]   red_frac,
  output logic [crp_pkg::FRAC_W-1:0]   green_frac,
  output logic [crp_pkg::FRAC_W-1:0]   blue_frac,
  output logic                         run_end,
  output logic                         too_few_stops
);
  import crp_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  crp_state_t        state, state_next;
  crp_phase_t        phase;

  logic [CW-1:0]     stop_cnt;
  logic [AW-1:0]     nseg;
  logic [AW-1:0]     seg_i;
  logic [SEG_W-1:0]  seg;
  logic [SEG_W-1:0]  j;
  logic [SEG_W-1:0]  nm1;
  logic [IDX_W-1:0]  cnt;
  logic [CFG_W-1:0]  n_eff;
  logic [COLOR_W-1:0] c0, c1;

  logic [PROD_W-1:0] pb [NUM_CH];
  logic [PROD_W-1:0] pa [NUM_CH];
  logic [PROD_W-1:0] sa [NUM_CH];
  logic [CH_W-1:0]   q_hi [NUM_CH];
  logic [CH_W-1:0]   q_lo [NUM_CH];
  logic [CH_W-1:0]   byte_q [NUM_CH];
  logic [FRAC_W-1:0] frac_q [NUM_CH];

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd [NUM_CH];
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done [NUM_CH];
  logic [FRAC_W-1:0] div_quo [NUM_CH];

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  logic              emit_entry, emit_last, emit_err;
  logic              gen_pop;
  logic              last_j, last_seg;

  assign gen_pop  = (state == ST_IDLE) && cmd_valid && (cmd.op == OP_GEN);
  assign last_j   = (j == seg - 1'b1);
  assign last_seg = ((seg_i + 1'b1) == nseg);

  // requested length, saturated to MAX_OUT, zero taken as one
  always_comb begin
    n_eff = out_count;
    if (out_count > CFG_W'(MAX_OUT)) begin
      n_eff = CFG_W'(MAX_OUT);
    end
    if (out_count == '0) begin
      n_eff = CFG_W'(1);
    end
  end

  crp_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_STOPS)) u_stops (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stop_cnt[AW-1:0]),
    .wdata (cmd.color),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider operands: segment size first, then j*c1/seg, j*c0/seg, rounded fraction
  always_comb begin
    logic [PROD_W:0] xs;
    xs = '0;
    if (state == ST_SEGST) begin
      div_dvs = DVS_W'(nseg);
    end else if (phase == PH_FRAC) begin
      div_dvs = {seg, 1'b0};
    end else begin
      div_dvs = {1'b0, seg};
    end
    for (int k = 0; k < NUM_CH; k++) begin
      xs = {1'b0, pb[k]} + {1'b0, sa[k]};
      if (state == ST_SEGST) begin
        div_dvd[k] = DVD_W'(nm1);
      end else begin
        case (phase)
          PH_HI:   div_dvd[k] = DVD_W'(pb[k]);
          PH_LO:   div_dvd[k] = DVD_W'(pa[k]);
          PH_FRAC: div_dvd[k] = (DVD_W'(xs) << 9) + (DVD_W'(xs) << 1) + DVD_W'(seg);
          default: div_dvd[k] = '0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    crp_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (div_dvd[g]),
      .divisor  (div_dvs),
      .done     (div_done[g]),
      .quotient (div_quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = seg_i;
    div_start  = 1'b0;
    emit_entry = 1'b0;
    emit_last  = 1'b0;
    emit_err   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          if (cmd.op == OP_LOAD) begin
            ram_we = (stop_cnt < CW'(MAX_STOPS));
          end else if (stop_cnt < CW'(2)) begin
            state_next = ST_ERR;
          end else begin
            state_next = ST_SEGST;
          end
        end
      end
      ST_ERR: begin
        emit_err   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SEGST: begin
        div_start  = 1'b1;
        state_next = ST_SEGW;
      end
      ST_SEGW: begin
        if (div_done[0]) begin
          state_next = (div_quo[0][SEG_W-1:0] == '0) ? ST_LASTA : ST_RDA;
        end
      end
      ST_RDA: begin
        ram_raddr  = seg_i;
        state_next = ST_RDB;
      end
      ST_RDB: begin
        ram_raddr  = seg_i + 1'b1;
        state_next = ST_RDC;
      end
      ST_RDC:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done[0]) begin
          state_next = (phase == PH_FRAC) ? ST_EMIT : ST_DIV;
        end
      end
      ST_EMIT: begin
        emit_entry = 1'b1;
        if (last_j) begin
          state_next = last_seg ? ST_LAST : ST_RDA;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_LASTA: begin
        ram_raddr  = nseg;
        state_next = ST_LASTB;
      end
      ST_LASTB: state_next = ST_LAST;
      ST_LAST: begin
        emit_last  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_cnt <= '0;
    end else if (ram_we) begin
      stop_cnt <= stop_cnt + 1'b1;
    end else if (gen_pop) begin
      stop_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (gen_pop) begin
          nseg <= AW'(stop_cnt - 1'b1);
          nm1  <= SEG_W'(n_eff - 1'b1);
        end
      end
      ST_SEGW: begin
        if (div_done[0]) begin
          seg   <= div_quo[0][SEG_W-1:0];
          seg_i <= '0;
          j     <= '0;
          cnt   <= '0;
        end
      end
      ST_RDB:   c0 <= ram_rdata;
      ST_RDC:   c1 <= ram_rdata;
      ST_LASTB: c1 <= ram_rdata;
      ST_MUL: begin
        phase <= PH_HI;
        for (int k = 0; k < NUM_CH; k++) begin
          pb[k] <= PROD_W'(j) * PROD_W'(chan(c1, k));
          pa[k] <= PROD_W'(j) * PROD_W'(chan(c0, k));
          sa[k] <= PROD_W'(seg - j) * PROD_W'(chan(c0, k));
        end
      end
      ST_DIVW: begin
        if (div_done[0]) begin
          case (phase)
            PH_HI: begin
              phase <= PH_LO;
              for (int k = 0; k < NUM_CH; k++) q_hi[k] <= div_quo[k][CH_W-1:0];
            end
            PH_LO: begin
              phase <= PH_FRAC;
              for (int k = 0; k < NUM_CH; k++) q_lo[k] <= div_quo[k][CH_W-1:0];
            end
            default: phase <= PH_FRAC;
          endcase
        end
      end
      ST_EMIT: begin
        cnt <= cnt + 1'b1;
        if (last_j) begin
          j     <= '0;
          seg_i <= seg_i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_entry || emit_last || emit_err;
    end
  end

  // error: zeros; entry: interpolated byte and fraction; final stop: byte is the channel, fraction is 257 * channel
  always_ff @(posedge clk) begin
    if (emit_err) begin
      entry_index   <= '0;
      run_end       <= 1'b1;
      too_few_stops <= 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
        byte_q[k] <= '0;
        frac_q[k] <= '0;
      end
    end else if (emit_entry) begin
      entry_index   <= cnt;
      run_end       <= 1'b0;
      too_few_stops <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        byte_q[k] <= q_hi[k] + chan(c0, k) - q_lo[k];
        frac_q[k] <= div_quo[k];
      end
    end else if (emit_last) begin
      entry_index   <= cnt;
      run_end       <= 1'b1;
      too_few_stops <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        byte_q[k] <= chan(c1, k);
        frac_q[k] <= {chan(c1, k), chan(c1, k)};
      end
    end
  end

  assign red_byte   = byte_q[0];
  assign green_byte = byte_q[1];
  assign blue_byte  = byte_q[2];
  assign red_frac   = frac_q[0];
  assign green_frac = frac_q[1];
  assign blue_frac  = frac_q[2];

  a_j_in_seg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (j < seg))
    else $error("entry emitted past segment end");
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIVW) && div_done[0]) |-> (div_done[1] && div_done[2]))
    else $error("channel dividers out of step");
  a_run_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && run_end) |=> !result_valid)
    else $error("result directly after end of run");

endmodule

// File: rtl/core/piecewise_linear_color_ramp.sv
// Top level of the piecewise linear color ramp generator.
//
// Channel  Dir  Transfer                  Carries
// item     in   start && !busy            kind, stop_color
// result   out  result_valid, one cycle   entry_index, *_byte, *_frac, run_end, too_few_stops
// config   in   cfg_we                    cfg_wdata -> out_count
//
// Items enter a two-item queue; busy is high only while that queue is full.
// A load item is taken by the back end in its idle state. Generate pops the item and divides for the
// segment size, then makes each entry with three divides (channel lanes in parallel), reads the
// stop table per segment, and ends with the final stop (read anew when segment size is 0).
// Reset is synchronous: empties the queue, stop count to 0, out_count to 64.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module piecewise_linear_color_ramp #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_OUT   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [crp_pkg::COLOR_W-1:0]  stop_color,
  input  logic                         cfg_we,
  input  logic [crp_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                         result_valid,
  output logic [crp_pkg::IDX_W-1:0]    entry_index,
  output logic [crp_pkg::CH_W-1:0]     red_byte,
  output logic [crp_pkg::CH_W-1:0]     green_byte,
  output logic [crp_pkg::CH_W-1:0]     blue_byte,
  output logic [crp_pkg::FRAC_W-1:0]   red_frac,
  output logic [crp_pkg::FRAC_W-1:0]   green_frac,
  output logic [crp_pkg::FRAC_W-1:0]   blue_frac,
  output logic                         run_end,
  output logic                         too_few_stops
);
  import crp_pkg::*;

  logic [CFG_W-1:0] out_count;
  crp_cmd_t         cmd;
  logic             cmd_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= OUT_COUNT_RST;
    end else if (cfg_we) begin
      out_count <= cfg_wdata;
    end
  end

  crp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .stop_color (stop_color),
    .pop        (pop),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid)
  );

  crp_back #(.MAX_STOPS(MAX_STOPS), .MAX_OUT(MAX_OUT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .pop           (pop),
    .out_count     (out_count),
    .result_valid  (result_valid),
    .entry_index   (entry_index),
    .red_byte      (red_byte),
    .green_byte    (green_byte),
    .blue_byte     (blue_byte),
    .red_frac      (red_frac),
    .green_frac    (green_frac),
    .blue_frac     (blue_frac),
    .run_end       (run_end),
    .too_few_stops (too_few_stops)
  );

endmodule
